/* rtl/core/huffman_tree_bit_decoder_assert.svh */
// assertion macros used by the decoder back end
`ifndef HUFFMAN_TREE_BIT_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_BIT_DECODER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, quiet while in reset
`define HUFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HUFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/hufd_pkg.sv */
package hufd_pkg;

    localparam int BITS_IN_BYTE = 8;
    localparam int BIT_IDX_W    = $clog2(BITS_IN_BYTE);
    localparam logic [7:0] END_SYMBOL = 8'hFF;

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_DECODE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        KIND_SYMBOL = 2'd0,
        KIND_END    = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    typedef struct packed {
        t_op        op;
        logic       start;
        logic [7:0] data;
    } t_cmd;

    typedef enum logic [1:0] {
        B_IDLE,
        B_STEP,
        B_RESOLVE,
        B_FLUSH
    } t_bstate;

endpackage

/* rtl/core/hufd_ram.sv */
module hufd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/hufd_front.sv */
module hufd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_op,
    input  logic           i_tree_start,
    input  logic [7:0]     i_tree_entry,
    input  logic [7:0]     i_code_byte,
    output logic           o_cmd_valid,
    input  logic           i_cmd_ready,
    output hufd_pkg::t_cmd o_cmd
);

    import hufd_pkg::*;

    localparam int Q_DEPTH = 2;
    localparam int QPW     = $clog2(Q_DEPTH);
    localparam int QCW     = $clog2(Q_DEPTH + 1);

    t_cmd           r_slot [Q_DEPTH];
    logic [QPW-1:0] r_wptr;
    logic [QPW-1:0] r_rptr;
    logic [QCW-1:0] r_count;
    t_cmd           cmd_in;
    logic           push;
    logic           pop;

    // classify: one command word per item, payload picked by op
    always_comb begin
        cmd_in.op    = i_op ? OP_DECODE : OP_LOAD;
        cmd_in.start = !i_op && i_tree_start;
        cmd_in.data  = i_op ? i_code_byte : i_tree_entry;
    end

    assign o_ready     = (r_count != QCW'(Q_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_slot[r_rptr];
    assign push        = i_valid && o_ready;
    assign pop         = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + QPW'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + QPW'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + QCW'(1);
                2'b01:   r_count <= r_count - QCW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/core/hufd_back.sv */
module hufd_back #(
    parameter int MAX_NODES = 512
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  hufd_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_symbol,
    output logic [1:0]     o_kind,
    output logic           o_last
);

    import hufd_pkg::*;

    `include "huffman_tree_bit_decoder_assert.svh"

    localparam int AW = $clog2(MAX_NODES);
    localparam int EW = $clog2(MAX_NODES + 1);
    localparam int BW = $clog2(2 * MAX_NODES + 1);
    localparam int DW = 1 + 8 + BW;

    t_bstate              r_state, n_state;
    logic [EW-1:0]        r_entries, n_entries;
    logic [EW-1:0]        r_internal, n_internal;
    logic [BW-1:0]        r_base, n_base;
    logic [7:0]           r_root_sym, n_root_sym;
    logic                 r_done, n_done;
    logic [7:0]           r_code, n_code;
    logic [BIT_IDX_W-1:0] r_bit, n_bit;
    logic                 r_pend_valid, n_pend_valid;
    logic [7:0]           r_pend_sym, n_pend_sym;
    t_kind                r_pend_kind, n_pend_kind;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_out_sym, n_out_sym;
    t_kind                r_out_kind, n_out_kind;
    logic                 r_out_last, n_out_last;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [DW-1:0]        ram_wdata;
    logic                 ram_re;
    logic [DW-1:0]        ram_rdata;

    logic                 rd_internal;
    logic [7:0]           rd_sym;
    logic [BW-1:0]        rd_base;
    logic                 cur_bit;
    logic [BW-1:0]        next_idx;
    logic                 s_empty;
    logic                 s_single;
    logic                 s_oob;
    logic                 res_now;
    logic [7:0]           leaf_sym;
    t_kind                res_kind;
    logic                 res_final;
    logic                 out_free;
    logic                 can_emit;
    logic                 stall;
    logic                 last_bit;

    logic                 ld_start;
    logic [EW-1:0]        ld_idx;
    logic [EW-1:0]        ld_seen;
    logic                 ld_store;
    logic                 ld_internal;

    hufd_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_NODES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (next_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // table word: internal flag, symbol, child base
    assign rd_internal = ram_rdata[DW-1];
    assign rd_sym      = ram_rdata[DW-2 -: 8];
    assign rd_base     = ram_rdata[BW-1:0];

    assign cur_bit  = r_code[r_bit];
    assign next_idx = r_base + BW'(cur_bit);
    assign last_bit = (r_bit == '0);
    assign s_empty  = (r_entries == '0);
    assign s_single = (r_entries == EW'(1));
    assign s_oob    = (next_idx >= BW'(r_entries));
    assign out_free = !r_out_valid || i_ready;
    assign can_emit = !r_pend_valid || out_free;

    // what the current step yields
    always_comb begin
        res_now  = 1'b0;
        leaf_sym = r_root_sym;
        res_kind = KIND_SYMBOL;
        unique case (r_state)
            B_STEP: begin
                res_now  = s_empty || s_single || s_oob;
                leaf_sym = r_root_sym;
                if (s_empty || (!s_single && s_oob)) begin
                    res_kind = KIND_ERROR;
                end else if (r_root_sym == END_SYMBOL) begin
                    res_kind = KIND_END;
                end
            end
            B_RESOLVE: begin
                res_now  = !rd_internal;
                leaf_sym = rd_sym;
                if (rd_sym == END_SYMBOL) begin
                    res_kind = KIND_END;
                end
            end
            default: begin
                res_now = 1'b0;
            end
        endcase
    end

    assign res_final = (res_kind != KIND_SYMBOL);
    assign stall     = res_now && !can_emit;

    // load bookkeeping
    assign ld_start    = i_cmd.start;
    assign ld_idx      = ld_start ? '0 : r_entries;
    assign ld_seen     = ld_start ? '0 : r_internal;
    assign ld_store    = ld_start || (r_entries < EW'(MAX_NODES));
    assign ld_internal = (ld_idx == '0) || (i_cmd.data == '0);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_cmd_valid && i_cmd.op == OP_DECODE && !r_done) begin
                    n_state = B_STEP;
                end
            end
            B_STEP: begin
                if (stall) begin
                    n_state = B_STEP;
                end else if (res_now) begin
                    n_state = (res_final || last_bit) ? B_FLUSH : B_STEP;
                end else begin
                    n_state = B_RESOLVE;
                end
            end
            B_RESOLVE: begin
                if (stall) begin
                    n_state = B_RESOLVE;
                end else if ((res_now && res_final) || last_bit) begin
                    n_state = B_FLUSH;
                end else begin
                    n_state = B_STEP;
                end
            end
            B_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_entries    = r_entries;
        n_internal   = r_internal;
        n_base       = r_base;
        n_root_sym   = r_root_sym;
        n_done       = r_done;
        n_code       = r_code;
        n_bit        = r_bit;
        n_pend_valid = r_pend_valid;
        n_pend_sym   = r_pend_sym;
        n_pend_kind  = r_pend_kind;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_sym    = r_out_sym;
        n_out_kind   = r_out_kind;
        n_out_last   = r_out_last;
        o_cmd_ready  = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = ld_idx[AW-1:0];
        ram_wdata    = {ld_internal, i_cmd.data,
                        ld_internal ? BW'({ld_seen, 1'b1}) : BW'(0)};
        ram_re       = 1'b0;

        unique case (r_state)
            B_IDLE: begin
                o_cmd_ready = i_cmd_valid;
                if (i_cmd_valid) begin
                    if (i_cmd.op == OP_LOAD) begin
                        if (ld_start) begin
                            n_entries  = '0;
                            n_internal = '0;
                            n_base     = BW'(1);
                            n_done     = 1'b0;
                        end
                        if (ld_store) begin
                            ram_we     = 1'b1;
                            n_entries  = ld_idx + EW'(1);
                            n_internal = ld_seen + EW'(ld_internal);
                            if (ld_idx == '0) begin
                                n_root_sym = i_cmd.data;
                            end
                        end
                    end else begin
                        n_code = i_cmd.data;
                        n_bit  = BIT_IDX_W'(BITS_IN_BYTE - 1);
                    end
                end
            end
            B_STEP, B_RESOLVE: begin
                if (r_state == B_STEP && !res_now) begin
                    ram_re = 1'b1;
                end
                if (r_state == B_RESOLVE && rd_internal) begin
                    n_base = rd_base;
                    n_bit  = r_bit - BIT_IDX_W'(1);
                end
                if (res_now && !stall) begin
                    // previous result is known not to be the last one
                    if (r_pend_valid) begin
                        n_out_valid = 1'b1;
                        n_out_sym   = r_pend_sym;
                        n_out_kind  = r_pend_kind;
                        n_out_last  = 1'b0;
                    end
                    n_pend_valid = 1'b1;
                    n_pend_sym   = res_final ? 8'h00 : leaf_sym;
                    n_pend_kind  = res_kind;
                    n_base       = BW'(1);
                    n_bit        = r_bit - BIT_IDX_W'(1);
                    if (res_final) begin
                        n_done = 1'b1;
                    end
                end
            end
            B_FLUSH: begin
                if (r_pend_valid && out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sym    = r_pend_sym;
                    n_out_kind   = r_pend_kind;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                end
            end
            default: begin
                n_done = r_done;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_entries    <= '0;
            r_internal   <= '0;
            r_base       <= BW'(1);
            r_done       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_entries    <= n_entries;
            r_internal   <= n_internal;
            r_base       <= n_base;
            r_done       <= n_done;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_root_sym  <= n_root_sym;
        r_code      <= n_code;
        r_bit       <= n_bit;
        r_pend_sym  <= n_pend_sym;
        r_pend_kind <= n_pend_kind;
        r_out_sym   <= n_out_sym;
        r_out_kind  <= n_out_kind;
        r_out_last  <= n_out_last;
    end

    assign o_valid  = r_out_valid;
    assign o_symbol = r_out_sym;
    assign o_kind   = r_out_kind;
    assign o_last   = r_out_last;

    `HUFD_ASSERT_NOW(a_idle_no_pend, r_state == B_IDLE, !r_pend_valid, "result left pending at idle")
    `HUFD_ASSERT_NOW(a_resolve_tree, r_state == B_RESOLVE, r_entries > EW'(1), "table read on tiny tree")
    `HUFD_ASSERT_NOW(a_base_odd, 1'b1, r_base[0] == 1'b1, "child base must be odd")
    `HUFD_ASSERT_NOW(a_entries_max, 1'b1, r_entries <= EW'(MAX_NODES), "table count overflow")
    `HUFD_ASSERT_NEXT(a_final_done, res_now && !stall && res_final, r_done, "end or error not latched")

endmodule

/* rtl/core/huffman_tree_bit_decoder.sv */
// Huffman tree-walk decoder. Load a tree as level-order bytes (op 0, zero byte
// = internal node, tree_start opens a new tree), then send code bytes (op 1);
// each bit walks one level, MSB first, and every leaf reached gives one result
// (symbol, end of stream on 0xFF, or error on a missing child or an empty
// tree), with last set on the final result of the byte. Items go into a
// two-entry command queue, so the input keeps accepting until it is full
// while the walker works or the output stalls. A load is a single walker
// step; a code byte takes a dispatch step, a table read then a resolve for
// each bit (no table read for a one-entry tree), and a closing step, paced
// by the dependent read chain through the tree table. The table has no
// reset and needs no clearing pass; only loaded entries are ever read.
module huffman_tree_bit_decoder #(
    parameter int MAX_NODES = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_op,
    input  logic       i_tree_start,
    input  logic [7:0] i_tree_entry,
    input  logic [7:0] i_code_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_symbol,
    output logic [1:0] o_kind,
    output logic       o_last
);

    import hufd_pkg::*;

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;

    hufd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_tree_start (i_tree_start),
        .i_tree_entry (i_tree_entry),
        .i_code_byte  (i_code_byte),
        .o_cmd_valid  (cmd_valid),
        .i_cmd_ready  (cmd_ready),
        .o_cmd        (cmd)
    );

    hufd_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_symbol    (o_symbol),
        .o_kind      (o_kind),
        .o_last      (o_last)
    );

endmodule

/* sim/huffman_tree_bit_decoder_checker.sv */
module huffman_tree_bit_decoder_checker #(
    parameter int MAX_NODES = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_item_valid,
    input  logic       i_item_ready,
    input  logic       i_op,
    input  logic       i_tree_start,
    input  logic [7:0] i_tree_entry,
    input  logic [7:0] i_code_byte,
    input  logic       i_res_valid,
    input  logic       i_res_ready,
    input  logic [7:0] i_symbol,
    input  logic [1:0] i_kind,
    input  logic       i_last,
    output int         o_mismatches,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import hufd_pkg::*;

    localparam int AW = $clog2(MAX_NODES);
    localparam int EW = $clog2(MAX_NODES + 1);
    localparam int BW = $clog2(2 * MAX_NODES + 1);

    typedef struct packed {
        logic [7:0] symbol;
        t_kind      kind;
        logic       last;
    } t_decoded;

    // shadow copy of the tree table and walker
    logic [7:0]    sym_table      [MAX_NODES];
    logic [BW-1:0] child_table    [MAX_NODES];
    logic          internal_table [MAX_NODES];
    logic [EW-1:0] loaded_cnt;
    logic [EW-1:0] internal_cnt;
    logic [AW-1:0] walk_node;
    logic          halted;

    t_decoded   decoded_due [$];
    t_decoded   got;
    t_decoded   want;
    int         mismatch_cnt;

    function automatic t_decoded make_result(input logic [7:0] symbol, input t_kind kind);
        t_decoded r;
        r.symbol = symbol;
        r.kind   = kind;
        r.last   = 1'b0;
        return r;
    endfunction

    task automatic store_entry(input logic start, input logic [7:0] entry);
        if (start) begin
            loaded_cnt   = '0;
            internal_cnt = '0;
            walk_node    = '0;
            halted       = 1'b0;
        end
        // a full table drops the item
        if (loaded_cnt < MAX_NODES) begin
            sym_table[loaded_cnt[AW-1:0]] = entry;
            if (loaded_cnt == 0 || entry == 8'h00) begin
                internal_table[loaded_cnt[AW-1:0]] = 1'b1;
                child_table[loaded_cnt[AW-1:0]]    = BW'({internal_cnt, 1'b1});
                internal_cnt++;
            end else begin
                internal_table[loaded_cnt[AW-1:0]] = 1'b0;
                child_table[loaded_cnt[AW-1:0]]    = '0;
            end
            loaded_cnt++;
        end
    endtask

    task automatic walk_code_byte(input logic [7:0] code);
        int            first_new;
        int            next;
        logic [AW-1:0] pos;
        logic [7:0]    leaf;
        logic          reached;
        t_decoded      tail;

        first_new = decoded_due.size();
        leaf      = '0;
        for (int b = BITS_IN_BYTE - 1; b >= 0; b--) begin
            if (!halted) begin
                reached = 1'b1;
                if (loaded_cnt == 0) begin
                    decoded_due.push_back(make_result(8'h00, KIND_ERROR));
                    halted  = 1'b1;
                    reached = 1'b0;
                end else if (loaded_cnt == 1) begin
                    // lone root is a leaf on every bit
                    leaf = sym_table[0];
                end else begin
                    pos  = (walk_node >= loaded_cnt) ? '0 : walk_node;
                    next = int'(child_table[pos]) + int'(code[b]);
                    if (next >= loaded_cnt || next >= MAX_NODES) begin
                        decoded_due.push_back(make_result(8'h00, KIND_ERROR));
                        halted    = 1'b1;
                        walk_node = '0;
                        reached   = 1'b0;
                    end else if (internal_table[next[AW-1:0]]) begin
                        walk_node = next[AW-1:0];
                        reached   = 1'b0;
                    end else begin
                        leaf      = sym_table[next[AW-1:0]];
                        walk_node = '0;
                    end
                end
                if (reached) begin
                    if (leaf == END_SYMBOL) begin
                        decoded_due.push_back(make_result(8'h00, KIND_END));
                        halted    = 1'b1;
                        walk_node = '0;
                    end else begin
                        decoded_due.push_back(make_result(leaf, KIND_SYMBOL));
                    end
                end
            end
        end
        if (decoded_due.size() > first_new) begin
            tail      = decoded_due.pop_back();
            tail.last = 1'b1;
            decoded_due.push_back(tail);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            loaded_cnt   = '0;
            internal_cnt = '0;
            walk_node    = '0;
            halted       = 1'b0;
            mismatch_cnt = 0;
            decoded_due.delete();
        end else begin
            if (i_item_valid && i_item_ready) begin
                if (t_op'(i_op) == OP_LOAD) begin
                    store_entry(i_tree_start, i_tree_entry);
                end else begin
                    walk_code_byte(i_code_byte);
                end
            end
            if (i_res_valid && i_res_ready) begin
                got.symbol = i_symbol;
                got.kind   = t_kind'(i_kind);
                got.last   = i_last;
                if (decoded_due.size() == 0) begin
                    if (mismatch_cnt < 10) begin
                        $display("%0t unexpected result: symbol %02h kind %0d last %0d",
                                 $realtime, got.symbol, got.kind, got.last);
                    end
                    mismatch_cnt++;
                end else begin
                    want = decoded_due.pop_front();
                    if (got.symbol !== want.symbol || got.kind !== want.kind ||
                        got.last !== want.last) begin
                        if (mismatch_cnt < 10) begin
                            $display("%0t mismatch: exp %02h/%0d/%0d got %02h/%0d/%0d",
                                     $realtime, want.symbol, want.kind, want.last,
                                     got.symbol, got.kind, got.last);
                        end
                        mismatch_cnt++;
                    end
                end
            end
        end
        o_mismatches <= mismatch_cnt;
        o_pending    <= decoded_due.size();
    end

endmodule

/* sim/huffman_tree_bit_decoder_tb.sv */
module huffman_tree_bit_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hufd_pkg::*;

    localparam int NODE_LIMIT     = 512;
    localparam int RANDOM_ITEMS   = 300;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT    = 4000;
    localparam int SETTLE_CYCLES  = 80;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic       o_ready;
    logic       i_op         = 1'b0;
    logic       i_tree_start = 1'b0;
    logic [7:0] i_tree_entry = 8'h00;
    logic [7:0] i_code_byte  = 8'h00;
    logic       o_valid;
    logic       i_ready      = 1'b0;
    logic [7:0] o_symbol;
    logic [1:0] o_kind;
    logic       o_last;

    int         mismatches;
    int         pending;
    logic       no_gaps        = 1'b0;
    int         rx_holds_asked = 0;
    int         idle_cycles    = 0;
    logic [7:0] tree_q [$];

    huffman_tree_bit_decoder #(
        .MAX_NODES(NODE_LIMIT)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_tree_start(i_tree_start),
        .i_tree_entry(i_tree_entry),
        .i_code_byte (i_code_byte),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_symbol    (o_symbol),
        .o_kind      (o_kind),
        .o_last      (o_last)
    );

    huffman_tree_bit_decoder_checker #(
        .MAX_NODES(NODE_LIMIT)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_valid(i_valid),
        .i_item_ready(o_ready),
        .i_op        (i_op),
        .i_tree_start(i_tree_start),
        .i_tree_entry(i_tree_entry),
        .i_code_byte (i_code_byte),
        .i_res_valid (o_valid),
        .i_res_ready (i_ready),
        .i_symbol    (o_symbol),
        .i_kind      (o_kind),
        .i_last      (o_last),
        .o_mismatches(mismatches),
        .o_pending   (pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    task automatic send_item(input t_op op, input logic start, input logic [7:0] entry,
                             input logic [7:0] code);
        int gap;
        i_valid      <= 1'b1;
        i_op         <= op;
        i_tree_start <= start;
        i_tree_entry <= entry;
        i_code_byte  <= code;
        do @(posedge i_clk); while (!o_ready);
        gap = no_gaps ? 0 : int'($urandom_range(0, 3));
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // full binary tree in level order, children of the k-th internal node at 2k+1, 2k+2
    task automatic build_tree(input int max_len, input logic with_end);
        int open;
        int pick;
        tree_q.delete();
        tree_q.push_back(8'($urandom_range(0, 255)));
        open = 2;
        while (open > 0) begin
            if (tree_q.size() + open < max_len && $urandom_range(0, 99) < 55) begin
                tree_q.push_back(8'h00);
                open++;
            end else begin
                tree_q.push_back(8'($urandom_range(1, 254)));
                open--;
            end
        end
        if (with_end) begin
            do pick = int'($urandom_range(1, tree_q.size() - 1)); while (tree_q[pick] == 8'h00);
            tree_q[pick] = END_SYMBOL;
        end
    endtask

    // receiver: random back-pressure, one long hold when asked
    initial begin
        int n;
        int holds_served;
        holds_served = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_holds_asked != holds_served) begin
                holds_served++;
                i_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                n = no_gaps ? 0 : int'($urandom_range(0, 3));
                if (n != 0) begin
                    i_ready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int         item_total;
        int         tree_len;
        int         cut;
        int         n_bytes;
        int         phase;
        logic       hold_phase;
        logic [7:0] entry;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // nothing loaded yet, then the halted stream stays quiet
        send_item(OP_DECODE, 1'b0, 8'h00, 8'hA5);
        send_item(OP_DECODE, 1'b1, 8'hFF, 8'h3C);
        // lone root emits on every bit
        send_item(OP_LOAD, 1'b1, 8'h41, 8'h00);
        send_item(OP_DECODE, 1'b0, 8'h00, 8'h00);
        send_item(OP_LOAD, 1'b1, 8'h00, 8'hFF);
        send_item(OP_DECODE, 1'b0, 8'h00, 8'hFF);
        send_item(OP_LOAD, 1'b1, END_SYMBOL, 8'h00);
        send_item(OP_DECODE, 1'b0, 8'h00, 8'h12);
        send_item(OP_DECODE, 1'b0, 8'h00, 8'h34);
        // root with only its left child
        send_item(OP_LOAD, 1'b1, 8'h00, 8'h00);
        send_item(OP_LOAD, 1'b0, 8'h7E, 8'h00);
        send_item(OP_DECODE, 1'b0, 8'h00, 8'h40);
        // two leaves, end marker on the right
        send_item(OP_LOAD, 1'b1, 8'hC3, 8'h00);
        send_item(OP_LOAD, 1'b0, 8'h01, 8'h00);
        send_item(OP_LOAD, 1'b0, END_SYMBOL, 8'h00);
        send_item(OP_DECODE, 1'b0, 8'h00, 8'h00);
        send_item(OP_DECODE, 1'b0, 8'h00, 8'h01);
        send_item(OP_DECODE, 1'b0, 8'h00, 8'hFF);
        // appending does not restart a finished stream
        send_item(OP_LOAD, 1'b0, 8'h80, 8'h00);
        send_item(OP_DECODE, 1'b0, 8'h00, 8'h55);
        wait_drained();

        // fill the table: internal nodes 0..255, so node 255 wants entry 512,
        // which is the dropped item at the end
        no_gaps <= 1'b1;
        for (int i = 0; i <= NODE_LIMIT; i++) begin
            entry = ((i > 0 && i < NODE_LIMIT / 2) || i == NODE_LIMIT) ?
                    8'h00 : 8'($urandom_range(1, 254));
            send_item(OP_LOAD, i == 0, entry, 8'h00);
        end
        send_item(OP_DECODE, 1'b0, 8'h00, 8'h00);
        send_item(OP_DECODE, 1'b0, 8'h00, 8'h00);
        send_item(OP_DECODE, 1'b0, 8'h00, 8'h7F);
        wait_drained();

        // refill and walk random bytes through the deep tree
        for (int i = 0; i < NODE_LIMIT; i++) begin
            entry = (i > 0 && i < NODE_LIMIT / 2) ? 8'h00 : 8'($urandom_range(1, 254));
            send_item(OP_LOAD, i == 0, entry, 8'h00);
        end
        no_gaps <= 1'b0;
        for (int i = 0; i < 6; i++) begin
            send_item(OP_DECODE, 1'b0, 8'($urandom), 8'($urandom));
        end
        wait_drained();

        phase      = 0;
        item_total = 0;
        while (item_total < RANDOM_ITEMS) begin
            phase++;
            hold_phase = (phase == 4);
            no_gaps <= !hold_phase && ($urandom_range(0, 4) == 0);
            tree_len = ($urandom_range(0, 9) == 0) ? 120 : int'($urandom_range(3, 31));
            build_tree(tree_len, !hold_phase && $urandom_range(0, 2) == 0);
            cut = tree_q.size();
            // sometimes a truncated tree, so children go missing
            if (!hold_phase && $urandom_range(0, 5) == 0) cut = int'($urandom_range(1, cut));
            for (int i = 0; i < cut; i++) begin
                if ($urandom_range(0, 24) == 0) begin
                    send_item(OP_DECODE, 1'($urandom_range(0, 1)), 8'($urandom),
                              8'($urandom));
                    item_total++;
                end
                send_item(OP_LOAD, i == 0, tree_q[i], 8'($urandom));
                item_total++;
            end
            // receiver stalls while code bytes keep coming
            if (hold_phase) rx_holds_asked <= rx_holds_asked + 1;
            n_bytes = hold_phase ? 16 : int'($urandom_range(2, 12));
            for (int i = 0; i < n_bytes; i++) begin
                if ($urandom_range(0, 24) == 0) begin
                    send_item(OP_LOAD, 1'b0, 8'($urandom), 8'($urandom));
                    item_total++;
                end
                send_item(OP_DECODE, 1'($urandom_range(0, 1)), 8'($urandom), 8'($urandom));
                item_total++;
            end
            if (phase == 6 || $urandom_range(0, 3) == 0) wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
